FILE: hw/rtl/i2cms_pkg.sv
// Package for the I2C master bit sequencer.
// Command codes, slot lengths and the item/result structs; no dependencies.
`default_nettype none

package i2cms_pkg;

	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned IDX_W     = 5;
	localparam int unsigned PH_W      = 2;

	typedef enum logic [2:0] {
		CMD_START    = 3'd0,
		CMD_STOP     = 3'd1,
		CMD_WRITE    = 3'd2,
		CMD_READ     = 3'd3,
		CMD_SEND_ACK = 3'd4,
		CMD_RECV_ACK = 3'd5
	} cmd_t;

	localparam logic [PH_W-1:0] PH_FIRST = PH_W'(0);
	localparam logic [PH_W-1:0] PH_MID   = PH_W'(1);
	localparam logic [PH_W-1:0] PH_LAST  = PH_W'(2);

	localparam logic [IDX_W-1:0] RD_LAST_IDX = IDX_W'(3 * BYTE_BITS);

	typedef struct packed {
		logic                 command_valid;
		logic [2:0]           command;
		logic [BYTE_BITS-1:0] tx_byte;
		logic                 ack_to_send;
		logic                 sda_in;
	} slot_in_t;

	typedef struct packed {
		logic                 scl;
		logic                 sda_out;
		logic                 busy_res;
		logic                 done_res;
		logic [BYTE_BITS-1:0] rx_byte;
		logic                 ack_received;
	} slot_res_t;

	// index of the final slot of each command
	function automatic logic [IDX_W-1:0] last_slot(input cmd_t c);
		logic [IDX_W-1:0] r;
		unique case (c)
			CMD_START:    r = IDX_W'(3);
			CMD_STOP:     r = IDX_W'(2);
			CMD_WRITE:    r = IDX_W'(3 * BYTE_BITS - 1);
			CMD_READ:     r = IDX_W'(3 * BYTE_BITS);
			CMD_SEND_ACK: r = IDX_W'(2);
			CMD_RECV_ACK: r = IDX_W'(3);
			default:      r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/i2cms_if.sv
// Valid/ready channel interfaces for slot items and slot results.
// Depends on i2cms_pkg.
`default_nettype none

interface i2cms_slot_if import i2cms_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 command_valid;
	logic [2:0]           command;
	logic [BYTE_BITS-1:0] tx_byte;
	logic                 ack_to_send;
	logic                 sda_in;

	modport source (output valid, command_valid, command, tx_byte, ack_to_send, sda_in,
		input ready);
	modport sink (input valid, command_valid, command, tx_byte, ack_to_send, sda_in,
		output ready);
endinterface

interface i2cms_res_if import i2cms_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 scl;
	logic                 sda_out;
	logic                 busy_res;
	logic                 done_res;
	logic [BYTE_BITS-1:0] rx_byte;
	logic                 ack_received;

	modport source (output valid, scl, sda_out, busy_res, done_res, rx_byte, ack_received,
		input ready);
	modport sink (input valid, scl, sda_out, busy_res, done_res, rx_byte, ack_received,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/i2cms_slot_core.sv
// Sequencer state and the per-slot pin action logic.
// Depends on i2cms_pkg; state advances once per stepped slot.
`default_nettype none

module i2cms_slot_core import i2cms_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire slot_in_t  item,
	output slot_res_t      res
);

	cmd_t                 cmd_q, cmd_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [PH_W-1:0]      ph_q, ph_d;
	logic                 prog_q, prog_d;
	logic [BYTE_BITS-1:0] shift_q, shift_d;
	logic                 scl_q, scl_d;
	logic                 sda_q, sda_d;
	logic [BYTE_BITS-1:0] rxb_q, rxb_d;
	logic                 rack_q, rack_d;

	cmd_t                 e_cmd;
	logic [IDX_W-1:0]     e_idx;
	logic [PH_W-1:0]      e_ph;
	logic                 e_prog;
	logic [BYTE_BITS-1:0] e_shift;
	logic                 done;

	always_comb begin
		e_cmd   = cmd_q;
		e_idx   = idx_q;
		e_ph    = ph_q;
		e_prog  = prog_q;
		e_shift = shift_q;
		if (!prog_q && item.command_valid && item.command <= 3'(CMD_RECV_ACK)) begin
			e_cmd  = cmd_t'(item.command);
			e_idx  = '0;
			e_ph   = PH_FIRST;
			e_prog = 1'b1;
			if (cmd_t'(item.command) == CMD_WRITE)
				e_shift = item.tx_byte;
			else if (cmd_t'(item.command) == CMD_SEND_ACK)
				e_shift = {{(BYTE_BITS-1){1'b0}}, item.ack_to_send};
			else
				e_shift = '0;
		end

		cmd_d   = e_cmd;
		idx_d   = e_idx;
		ph_d    = e_ph;
		prog_d  = e_prog;
		shift_d = e_shift;
		scl_d   = scl_q;
		sda_d   = sda_q;
		rxb_d   = rxb_q;
		rack_d  = rack_q;
		done    = 1'b0;

		if (e_prog) begin
			unique case (e_cmd)
				CMD_START: begin
					priority if (e_idx == IDX_W'(0)) sda_d = 1'b1;
					else if (e_idx == IDX_W'(1)) scl_d = 1'b1;
					else if (e_idx == IDX_W'(2)) sda_d = 1'b0;
					else scl_d = 1'b0;
				end
				CMD_STOP: begin
					priority if (e_idx == IDX_W'(0)) sda_d = 1'b0;
					else if (e_idx == IDX_W'(1)) scl_d = 1'b1;
					else sda_d = 1'b1;
				end
				CMD_WRITE: begin
					priority if (e_ph == PH_FIRST) begin
						sda_d   = e_shift[BYTE_BITS-1];
						shift_d = {e_shift[BYTE_BITS-2:0], 1'b0};
					end else if (e_ph == PH_MID) scl_d = 1'b1;
					else scl_d = 1'b0;
				end
				CMD_READ: begin
					priority if (e_idx == IDX_W'(0)) sda_d = 1'b1;
					else if (e_ph == PH_FIRST) scl_d = 1'b1;
					else if (e_ph == PH_MID) shift_d = {e_shift[BYTE_BITS-2:0], item.sda_in};
					else begin
						scl_d = 1'b0;
						if (e_idx == RD_LAST_IDX) rxb_d = e_shift;
					end
				end
				CMD_SEND_ACK: begin
					priority if (e_idx == IDX_W'(0)) sda_d = e_shift[0];
					else if (e_idx == IDX_W'(1)) scl_d = 1'b1;
					else scl_d = 1'b0;
				end
				CMD_RECV_ACK: begin
					priority if (e_idx == IDX_W'(0)) sda_d = 1'b1;
					else if (e_idx == IDX_W'(1)) scl_d = 1'b1;
					else if (e_idx == IDX_W'(2)) rack_d = item.sda_in;
					else scl_d = 1'b0;
				end
				default: ;
			endcase

			// read spends its first slot releasing SDA before the bit phases start
			if (e_cmd == CMD_READ && e_idx == IDX_W'(0))
				ph_d = PH_FIRST;
			else
				ph_d = (e_ph == PH_LAST) ? PH_FIRST : e_ph + PH_W'(1);

			if (e_idx >= last_slot(e_cmd)) begin
				done   = 1'b1;
				prog_d = 1'b0;
				idx_d  = '0;
			end else begin
				idx_d = e_idx + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_START;
			idx_q   <= '0;
			ph_q    <= PH_FIRST;
			prog_q  <= 1'b0;
			shift_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rxb_q   <= '0;
			rack_q  <= 1'b1;
		end else if (step) begin
			cmd_q   <= cmd_d;
			idx_q   <= idx_d;
			ph_q    <= ph_d;
			prog_q  <= prog_d;
			shift_q <= shift_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			rxb_q   <= rxb_d;
			rack_q  <= rack_d;
		end
	end

	assign res.scl          = scl_d;
	assign res.sda_out      = sda_d;
	assign res.busy_res     = prog_d;
	assign res.done_res     = done;
	assign res.rx_byte      = rxb_d;
	assign res.ack_received = rack_d;

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: input register, slot core, result register.
// Depends on i2cms_pkg, i2cms_if and i2cms_slot_core.
`default_nettype none

// Each transfer on cmd is one bus timing slot and yields exactly one transfer on res
// carrying the pin levels after that slot. A slot is held first in the input register
// and then in the result register; one slot is taken every cycle, and the only stall
// comes from res.ready. A command is taken only while no sequence
// runs (start 4, stop 3, write 24, read 25, send ack 3, receive ack 4 slots); commands
// offered while busy, and codes 6 and 7, are ignored. Pins are open-drain, 1 released.
module i2c_master_bit_sequencer import i2cms_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	i2cms_slot_if.sink  cmd,
	i2cms_res_if.source res
);

	slot_in_t  item_s1;
	logic      valid_s1;
	slot_res_t res_s2;
	slot_res_t res_c;
	logic      valid_s2;
	logic      step;

	assign step      = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) valid_s1 <= cmd.valid;
			if (step) valid_s2 <= 1'b1;
			else if (res.ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.command_valid <= cmd.command_valid;
			item_s1.command       <= cmd.command;
			item_s1.tx_byte       <= cmd.tx_byte;
			item_s1.ack_to_send   <= cmd.ack_to_send;
			item_s1.sda_in        <= cmd.sda_in;
		end
		if (step) res_s2 <= res_c;
	end

	i2cms_slot_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res_c)
	);

	assign res.valid        = valid_s2;
	assign res.scl          = res_s2.scl;
	assign res.sda_out      = res_s2.sda_out;
	assign res.busy_res     = res_s2.busy_res;
	assign res.done_res     = res_s2.done_res;
	assign res.rx_byte      = res_s2.rx_byte;
	assign res.ack_received = res_s2.ack_received;

`ifndef NO_ASSERTIONS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.done_res && res_s2.busy_res))
		else $error("done and busy set in the same slot");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> cmd.ready)
		else $error("input stalled with empty result register");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(item_s1))
		else $error("stalled slot lost from input register");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && valid_s2 && res_s2.busy_res && !res_c.busy_res |-> res_c.done_res)
		else $error("sequence ended without a final slot");
`endif

endmodule

`default_nettype wire
